@@ rtl/core/ghp_pkg.sv @@
// Shared types and constants for the gzip header parser.
// No dependencies; used by gzip_header_parser and ghp_checker.
`default_nettype none

package ghp_pkg;

    localparam int unsigned LengthWidth  = 32;
    localparam int unsigned AddrWidth    = 3;
    localparam int unsigned DataWidth    = 32;

    localparam logic [LengthWidth-1:0] Framing      = LengthWidth'(18);
    localparam logic [LengthWidth-1:0] TrailerBytes = LengthWidth'(8);
    localparam logic [LengthWidth-1:0] LastHeadPos  = LengthWidth'(9);

    localparam logic [AddrWidth-1:0] AddrStreamLength = AddrWidth'(0);

    localparam logic [7:0] Magic0      = 8'h1f;
    localparam logic [7:0] Magic1      = 8'h8b;
    localparam logic [7:0] MethodDefl  = 8'h08;
    localparam logic [7:0] FlagRsvd    = 8'he0;
    localparam logic [7:0] FlagExtra   = 8'h04;
    localparam logic [7:0] FlagName    = 8'h08;
    localparam logic [7:0] FlagComment = 8'h10;
    localparam logic [7:0] FlagHcrc    = 8'h02;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_HEAD    = 4'd1,
        PH_XLEN0   = 4'd2,
        PH_XLEN1   = 4'd3,
        PH_EXTRA   = 4'd4,
        PH_NAME    = 4'd5,
        PH_COMMENT = 4'd6,
        PH_HCRC0   = 4'd7,
        PH_HCRC1   = 4'd8,
        PH_FINAL   = 4'd9
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_TOO_SHORT    = 4'd1,
        ST_BAD_MAGIC    = 4'd2,
        ST_RSVD_FLAGS   = 4'd3,
        ST_XLEN_CUT     = 4'd4,
        ST_EXTRA_CUT    = 4'd5,
        ST_NAME_OPEN    = 4'd6,
        ST_COMMENT_OPEN = 4'd7,
        ST_HCRC_CUT     = 4'd8,
        ST_NO_PAYLOAD   = 4'd9
    } t_status;

endpackage

`default_nettype wire

@@ rtl/core/gzip_header_parser.sv @@
// Top level of the gzip member header parser: byte-serial header walk,
// result register with one skid stage, APB-style length register.
// Depends on ghp_pkg.
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  ---------------------------------
//   input     in         i_valid / o_stall    i_data_byte, i_stream_start
//   result    out        o_valid / i_stall    o_status, o_payload_offset
//   config    in         psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// One byte per cycle while o_stall is low: each accepted byte updates the parse
// state in the same cycle, so the sustained rate is one byte every clock.
// A result is registered in the output register, or in the skid stage when stalled.
// The room check (one 32-bit subtract and compare against the trailer mark)
// is the longest path between the state registers.
// Reset (i_rst_n low, synchronous) leaves the parser idle and both result
// slots empty; bytes before the first stream start give nothing.
// A stalled result holds in the output register; one more result fits in the
// skid stage, and o_stall rises only while the skid stage is occupied.
`default_nettype none

module gzip_header_parser (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // byte input
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [7:0]                            i_data_byte,
    input  wire logic                                  i_stream_start,
    // result output
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [3:0]                                 o_status,
    output logic [31:0]                                o_payload_offset,
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ghp_pkg::AddrWidth-1:0]         paddr,
    input  wire logic [ghp_pkg::DataWidth-1:0]         pwdata,
    output logic [ghp_pkg::DataWidth-1:0]              prdata,
    output logic                                       pready
);

    localparam int unsigned LW = ghp_pkg::LengthWidth;

    typedef struct packed {
        logic             done;
        ghp_pkg::t_status status;
        ghp_pkg::t_phase  phase;
    } t_resolve;

    // Pick the next optional field starting at 'from', or close the header.
    function automatic t_resolve resolve(
        input ghp_pkg::t_phase from,
        input logic [7:0]      flags,
        input logic            room_zero,
        input logic            room_lt2
    );
        t_resolve r;
        r.done   = 1'b1;
        r.status = ghp_pkg::ST_OK;
        r.phase  = ghp_pkg::PH_IDLE;
        if (from <= ghp_pkg::PH_XLEN0 && (flags & ghp_pkg::FlagExtra) != 8'h00) begin
            if (room_lt2) begin
                r.status = ghp_pkg::ST_XLEN_CUT;
            end else begin
                r.done  = 1'b0;
                r.phase = ghp_pkg::PH_XLEN0;
            end
        end else if (from <= ghp_pkg::PH_NAME && (flags & ghp_pkg::FlagName) != 8'h00) begin
            if (room_zero) begin
                r.status = ghp_pkg::ST_NAME_OPEN;
            end else begin
                r.done  = 1'b0;
                r.phase = ghp_pkg::PH_NAME;
            end
        end else if (from <= ghp_pkg::PH_COMMENT &&
                     (flags & ghp_pkg::FlagComment) != 8'h00) begin
            if (room_zero) begin
                r.status = ghp_pkg::ST_COMMENT_OPEN;
            end else begin
                r.done  = 1'b0;
                r.phase = ghp_pkg::PH_COMMENT;
            end
        end else if (from <= ghp_pkg::PH_HCRC0 && (flags & ghp_pkg::FlagHcrc) != 8'h00) begin
            if (room_lt2) begin
                r.status = ghp_pkg::ST_HCRC_CUT;
            end else begin
                r.done  = 1'b0;
                r.phase = ghp_pkg::PH_HCRC0;
            end
        end else if (room_zero) begin
            r.status = ghp_pkg::ST_NO_PAYLOAD;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Configuration: stream length and the derived trailer mark
    // ---------------------------------------------------------------------
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_trailer;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr == ghp_pkg::AddrStreamLength);
    assign prdata = (paddr == ghp_pkg::AddrStreamLength) ? r_len : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_trailer <= '0;
        end else if (cfg_wr) begin
            r_len     <= pwdata;
            // trailer mark: first byte position of the 8-byte trailer
            r_trailer <= (pwdata > ghp_pkg::TrailerBytes) ? pwdata - ghp_pkg::TrailerBytes
                                                          : '0;
        end
    end

    // ---------------------------------------------------------------------
    // Parse state
    // ---------------------------------------------------------------------
    ghp_pkg::t_phase r_phase, n_phase;
    logic [LW-1:0]   r_pos, n_pos;     // bytes taken in this stream
    logic [LW-1:0]   r_pos1, n_pos1;   // r_pos + 1, kept to shorten the room path
    logic [7:0]      r_flags, n_flags;
    logic [15:0]     r_extra, n_extra;
    logic            r_given, n_given;

    // result of the byte being accepted
    logic             res_valid;
    ghp_pkg::t_status res_status;
    logic [LW-1:0]    res_offset;

    logic            in_acc;
    logic            start;
    ghp_pkg::t_phase cur_phase;
    logic [LW-1:0]   cur_pos;
    logic [LW-1:0]   cur_pos1;
    logic [7:0]      cur_flags;
    logic [15:0]     cur_extra;
    logic            cur_given;
    logic [LW:0]     room_diff;
    logic [LW-1:0]   room;
    logic            room_zero;
    logic            room_lt2;
    logic [15:0]     xlen;
    logic [15:0]     extra_dec;
    t_resolve        rs;

    assign in_acc = i_valid & ~o_stall;
    assign start  = i_stream_start;

    // Room before the trailer, measured after this byte is counted.
    assign cur_pos1  = start ? LW'(1) : r_pos1;
    assign room_diff = {1'b0, r_trailer} - {1'b0, cur_pos1};
    assign room      = (room_diff[LW] || room_diff[LW-1:0] == '0) ? '0 : room_diff[LW-1:0];
    assign room_zero = (room == '0);
    assign room_lt2  = (room[LW-1:1] == '0);

    assign xlen      = {i_data_byte, r_extra[7:0]};
    assign extra_dec = r_extra - 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ghp_pkg::PH_IDLE;
            r_given <= 1'b1;
            r_pos   <= '0;
            r_pos1  <= LW'(1);
            r_flags <= '0;
            r_extra <= '0;
        end else begin
            r_phase <= n_phase;
            r_given <= n_given;
            r_pos   <= n_pos;
            r_pos1  <= n_pos1;
            r_flags <= n_flags;
            r_extra <= n_extra;
        end
    end

    always_comb begin
        // start byte restarts the stream before the byte is parsed
        cur_phase = start ? ghp_pkg::PH_HEAD : r_phase;
        cur_pos   = start ? '0 : r_pos;
        cur_flags = start ? '0 : r_flags;
        cur_extra = start ? '0 : r_extra;
        cur_given = start ? 1'b0 : r_given;

        n_phase    = r_phase;
        n_pos      = r_pos;
        n_pos1     = r_pos1;
        n_flags    = r_flags;
        n_extra    = r_extra;
        n_given    = r_given;
        res_valid  = 1'b0;
        res_status = ghp_pkg::ST_OK;
        rs         = '{done: 1'b0, status: ghp_pkg::ST_OK, phase: ghp_pkg::PH_IDLE};

        if (in_acc) begin
            n_phase = cur_phase;
            n_pos   = cur_pos;
            n_pos1  = cur_pos + LW'(1);
            n_flags = cur_flags;
            n_extra = cur_extra;
            n_given = cur_given;

            if (start && r_len < ghp_pkg::Framing) begin
                res_valid  = 1'b1;
                res_status = ghp_pkg::ST_TOO_SHORT;
            end else if (!cur_given) begin
                n_pos  = cur_pos1;
                n_pos1 = cur_pos1 + LW'(1);
                case (cur_phase)
                    ghp_pkg::PH_HEAD: begin
                        if ((cur_pos == LW'(0) && i_data_byte != ghp_pkg::Magic0) ||
                            (cur_pos == LW'(1) && i_data_byte != ghp_pkg::Magic1) ||
                            (cur_pos == LW'(2) && i_data_byte != ghp_pkg::MethodDefl)) begin
                            res_valid  = 1'b1;
                            res_status = ghp_pkg::ST_BAD_MAGIC;
                        end else if (cur_pos == LW'(3)) begin
                            n_flags = i_data_byte;
                            if ((i_data_byte & ghp_pkg::FlagRsvd) != 8'h00) begin
                                res_valid  = 1'b1;
                                res_status = ghp_pkg::ST_RSVD_FLAGS;
                            end
                        end else if (cur_pos == ghp_pkg::LastHeadPos) begin
                            rs = resolve(ghp_pkg::PH_XLEN0, cur_flags, room_zero, room_lt2);
                        end
                    end
                    ghp_pkg::PH_XLEN0: begin
                        n_extra = {8'h00, i_data_byte};
                        n_phase = ghp_pkg::PH_XLEN1;
                    end
                    ghp_pkg::PH_XLEN1: begin
                        n_extra = xlen;
                        if ({{(LW-16){1'b0}}, xlen} > room) begin
                            res_valid  = 1'b1;
                            res_status = ghp_pkg::ST_EXTRA_CUT;
                        end else if (xlen == 16'd0) begin
                            rs = resolve(ghp_pkg::PH_NAME, cur_flags, room_zero, room_lt2);
                        end else begin
                            n_phase = ghp_pkg::PH_EXTRA;
                        end
                    end
                    ghp_pkg::PH_EXTRA: begin
                        n_extra = extra_dec;
                        if (extra_dec == 16'd0) begin
                            rs = resolve(ghp_pkg::PH_NAME, cur_flags, room_zero, room_lt2);
                        end else if (room_zero) begin
                            res_valid  = 1'b1;
                            res_status = ghp_pkg::ST_EXTRA_CUT;
                        end
                    end
                    ghp_pkg::PH_NAME: begin
                        if (i_data_byte == 8'h00) begin
                            rs = resolve(ghp_pkg::PH_COMMENT, cur_flags, room_zero, room_lt2);
                        end else if (room_zero) begin
                            res_valid  = 1'b1;
                            res_status = ghp_pkg::ST_NAME_OPEN;
                        end
                    end
                    ghp_pkg::PH_COMMENT: begin
                        if (i_data_byte == 8'h00) begin
                            rs = resolve(ghp_pkg::PH_HCRC0, cur_flags, room_zero, room_lt2);
                        end else if (room_zero) begin
                            res_valid  = 1'b1;
                            res_status = ghp_pkg::ST_COMMENT_OPEN;
                        end
                    end
                    ghp_pkg::PH_HCRC0: begin
                        n_phase = ghp_pkg::PH_HCRC1;
                    end
                    ghp_pkg::PH_HCRC1: begin
                        rs = resolve(ghp_pkg::PH_FINAL, cur_flags, room_zero, room_lt2);
                    end
                    default: begin
                        n_phase = ghp_pkg::PH_IDLE;
                        n_given = 1'b1;
                    end
                endcase

                if (rs.done) begin
                    res_valid  = 1'b1;
                    res_status = rs.status;
                end else if (rs.phase != ghp_pkg::PH_IDLE) begin
                    n_phase = rs.phase;
                end
            end

            // any result closes the stream
            if (res_valid) begin
                n_phase = ghp_pkg::PH_IDLE;
                n_given = 1'b1;
            end
        end
    end

    // ok offset is the count of bytes taken so far, including this one
    assign res_offset = (res_status == ghp_pkg::ST_OK) ? cur_pos1 : '0;

    // ---------------------------------------------------------------------
    // Result register and skid stage
    // ---------------------------------------------------------------------
    logic             r_out_valid;
    ghp_pkg::t_status r_out_status;
    logic [LW-1:0]    r_out_offset;
    logic             r_skid_valid;
    ghp_pkg::t_status r_skid_status;
    logic [LW-1:0]    r_skid_offset;
    logic             out_free;

    // output slot takes new data when empty or being drained this cycle
    assign out_free = ~r_out_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_status <= r_skid_status;
                r_out_offset <= r_skid_offset;
            end else if (res_valid) begin
                r_out_status <= res_status;
                r_out_offset <= res_offset;
            end
        end else if (res_valid) begin
            r_skid_status <= res_status;
            r_skid_offset <= res_offset;
        end
    end

    assign o_stall          = r_skid_valid;
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_payload_offset = r_out_offset;

endmodule

`default_nettype wire

@@ rtl/core/ghp_checker.sv @@
// Port-level checks for gzip_header_parser, bound to the top level.
// Depends on ghp_pkg.
`default_nettype none

module ghp_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_stall,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire logic [3:0]                        o_status,
    input wire logic [31:0]                       o_payload_offset
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_payload_offset))
        else $error("stalled result changed");

    // errors carry no offset
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ghp_pkg::ST_OK |-> o_payload_offset == 32'd0)
        else $error("error result with nonzero offset");

    // a payload never starts inside the fixed header
    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ghp_pkg::ST_OK |-> o_payload_offset >= 32'd10)
        else $error("payload offset inside fixed header");

    // input stalls only while both result slots are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

endmodule

bind gzip_header_parser ghp_checker u_ghp_checker (.*);

`default_nettype wire
